>>> src/tccw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared types and constants for the text console character writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

   // screen geometry defaults
   localparam int COLUMNS_DEFAULT = 80;
   localparam int ROWS_DEFAULT    = 25;

   // fixed field widths
   localparam int LOC_W      = 11;
   localparam int CELL_W     = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 4;

   // request modes
   localparam logic [1:0] MODE_PUT        = 2'd0;
   localparam logic [1:0] MODE_CLEAR      = 2'd1;
   localparam logic [1:0] MODE_SET_CURSOR = 2'd2;
   localparam logic [1:0] MODE_READ       = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BACKGROUND = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FOREGROUND = 1'b1;

   // character codes and cell values
   localparam logic [7:0]        CHAR_BACKSPACE      = 8'h08;
   localparam logic [7:0]        CHAR_NEWLINE        = 8'h0A;
   localparam logic [7:0]        CHAR_SPACE          = 8'h20;
   localparam logic [7:0]        CHAR_LAST_PRINTABLE = 8'h7F;
   localparam logic [3:0]        CLEAR_FOREGROUND    = 4'hF;
   localparam logic [CELL_W-1:0] BLANK_CELL          = 16'h0F20;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] char_code;
      logic [3:0] clear_colour;
      logic [6:0] cursor_column;
      logic [4:0] cursor_row;
      logic [10:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [LOC_W-1:0]  cursor_location;
      logic [CELL_W-1:0] cell_data;
   } rsp_type;

endpackage

>>> src/tccw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tccw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/text_console_char_writer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_char_writer_unit
// Text console: screen store of 16-bit cells plus a cursor, with put char,
// clear, set cursor and read cell requests.
// ----------------------------------------------------------------------------
//  channel   ports                          direction  handshake
//  request   start, busy, req_data          in         start & !busy
//  result    rsp_valid, rsp_data            out        one-cycle strobe
//  csr       csr_valid, csr_ready, csr_*    in         valid & ready
//
// Put char, set cursor and read cell pass from accept through ST_DONE to the
// result strobe. A put char that scrolls also passes ST_COPY and ST_BLANK, and
// a clear ST_FILL: both walk the store one cell per cycle on its write port.
// After reset a clearing pass (ST_INIT) blanks every cell of the store; busy
// is high until it ends. The result strobe cannot be stalled.
// ----------------------------------------------------------------------------
module text_console_char_writer_unit #(
   parameter int COLUMNS = tccw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = tccw_pkg::ROWS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  tccw_pkg::req_type               req_data,
   output logic                            rsp_valid,
   output tccw_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [tccw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tccw_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int COPY_COUNT = (ROWS - 1) * COLUMNS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int CALC_W     = ADDR_W + tccw_pkg::LOC_W;
   localparam int COL_W      = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int ROW_W      = $clog2(ROWS);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_FILL,
      ST_COPY,
      ST_BLANK,
      ST_DONE
   } state_type;

   state_type                     state_ff, state_in;
   logic [ADDR_W-1:0]             cnt_ff, cnt_in;
   logic [COL_W-1:0]              col_ff, col_in;
   logic [ROW_W-1:0]              row_ff, row_in;
   logic [3:0]                    bg_ff, bg_in;
   logic [3:0]                    fg_ff, fg_in;
   logic [tccw_pkg::CELL_W-1:0]   fill_ff, fill_in;
   logic                          hit_ff, hit_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   tccw_pkg::rsp_type             rsp_ff, rsp_in;

   logic                          accept;
   logic                          printable;
   logic [7:0]                    col_x;
   logic [6:0]                    row_x;
   logic [6:0]                    col_sat;
   logic [6:0]                    row_sat;
   logic [CALC_W-1:0]             loc_full;
   logic                          in_range;
   logic                          wr_en;
   logic [ADDR_W-1:0]             wr_addr;
   logic [tccw_pkg::CELL_W-1:0]   wr_data;
   logic [ADDR_W-1:0]             rd_addr;
   logic [tccw_pkg::CELL_W-1:0]   rd_data;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // linear cursor location
   assign loc_full = CALC_W'(row_ff) * CALC_W'(COLUMNS) + CALC_W'(col_ff);
   assign in_range = CALC_W'(req_data.cell_index) < CALC_W'(CELL_COUNT);
   assign printable = (req_data.char_code >= tccw_pkg::CHAR_SPACE) &&
                      (req_data.char_code <= tccw_pkg::CHAR_LAST_PRINTABLE);

   // put char cursor update: move, then wrap
   always_comb begin
      col_x = 8'(col_ff);
      row_x = 7'(row_ff);
      if (req_data.char_code == tccw_pkg::CHAR_BACKSPACE) begin
         if (col_x != 8'd0) begin
            col_x = col_x - 8'd1;
         end
      end else if (req_data.char_code == tccw_pkg::CHAR_NEWLINE) begin
         col_x = 8'd0;
         row_x = row_x + 7'd1;
      end else if (printable) begin
         col_x = col_x + 8'd1;
      end
      if (col_x >= 8'(COLUMNS)) begin
         col_x = 8'd0;
         row_x = row_x + 7'd1;
      end
   end

   // set cursor saturation
   assign col_sat = (req_data.cursor_column > 7'(COLUMNS - 1)) ?
                    7'(COLUMNS - 1) : req_data.cursor_column;
   assign row_sat = (7'(req_data.cursor_row) > 7'(ROWS - 1)) ?
                    7'(ROWS - 1) : 7'(req_data.cursor_row);

   // store ports
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cnt_ff;
      wr_data = tccw_pkg::BLANK_CELL;
      rd_addr = ADDR_W'(req_data.cell_index);
      unique case (state_ff)
         ST_INIT, ST_BLANK: begin
            wr_en = 1'b1;
         end
         ST_FILL: begin
            wr_en   = 1'b1;
            wr_data = fill_ff;
         end
         ST_COPY: begin
            // read one row ahead, write the previous cell
            wr_en   = (cnt_ff != '0);
            wr_addr = cnt_ff - ADDR_W'(1);
            wr_data = rd_data;
            rd_addr = ADDR_W'((ADDR_W + 1)'(cnt_ff) + (ADDR_W + 1)'(COLUMNS));
         end
         ST_IDLE: begin
            if (accept && req_data.mode == tccw_pkg::MODE_PUT && printable) begin
               wr_en   = 1'b1;
               wr_addr = loc_full[ADDR_W-1:0];
               wr_data = {bg_ff, fg_ff, req_data.char_code};
            end
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      bg_in        = bg_ff;
      fg_in        = fg_ff;
      fill_in      = fill_ff;
      hit_in       = hit_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      // register writes
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            tccw_pkg::CSR_BACKGROUND: bg_in = csr_data;
            tccw_pkg::CSR_FOREGROUND: fg_in = csr_data;
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         ST_INIT: begin
            cnt_in = cnt_ff + ADDR_W'(1);
            if (cnt_ff == ADDR_W'(CELL_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               hit_in   = 1'b0;
               cnt_in   = '0;
               state_in = ST_DONE;
               unique case (req_data.mode)
                  tccw_pkg::MODE_PUT: begin
                     col_in = COL_W'(col_x);
                     if (row_x >= 7'(ROWS)) begin
                        row_in   = ROW_W'(ROWS - 1);
                        state_in = ST_COPY;
                     end else begin
                        row_in = ROW_W'(row_x);
                     end
                  end
                  tccw_pkg::MODE_CLEAR: begin
                     col_in   = '0;
                     row_in   = '0;
                     fill_in  = {req_data.clear_colour, tccw_pkg::CLEAR_FOREGROUND,
                                 tccw_pkg::CHAR_SPACE};
                     state_in = ST_FILL;
                  end
                  tccw_pkg::MODE_SET_CURSOR: begin
                     col_in = COL_W'(col_sat);
                     row_in = ROW_W'(row_sat);
                  end
                  tccw_pkg::MODE_READ: begin
                     hit_in = in_range;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FILL: begin
            cnt_in = cnt_ff + ADDR_W'(1);
            if (cnt_ff == ADDR_W'(CELL_COUNT - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_COPY: begin
            cnt_in = cnt_ff + ADDR_W'(1);
            if (cnt_ff == ADDR_W'(COPY_COUNT)) begin
               cnt_in   = ADDR_W'(COPY_COUNT);
               state_in = ST_BLANK;
            end
         end
         ST_BLANK: begin
            cnt_in = cnt_ff + ADDR_W'(1);
            if (cnt_ff == ADDR_W'(CELL_COUNT - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            rsp_valid_in           = 1'b1;
            rsp_in.cursor_location = loc_full[tccw_pkg::LOC_W-1:0];
            rsp_in.cell_data       = hit_ff ? rd_data : '0;
            state_in               = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         bg_ff        <= 4'd0;
         fg_ff        <= 4'd15;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         bg_ff        <= bg_in;
         fg_ff        <= fg_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fill_ff <= fill_in;
      rsp_ff  <= rsp_in;
   end

   // screen store
   tccw_ram #(
      .WIDTH (tccw_pkg::CELL_W),
      .DEPTH (CELL_COUNT)
   ) u_screen (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the text console character writer. A shadow copy
// of the screen store, cursor and colour registers predicts every response.
// Directed requests cover the edges first, then phases of random text lines,
// cell reads, clears and noise run under several colour settings.
// ----------------------------------------------------------------------------
module testbench;
   import tccw_pkg::*;

   localparam int SCREEN_COLUMNS = COLUMNS_DEFAULT;
   localparam int SCREEN_ROWS    = ROWS_DEFAULT;
   localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;
   localparam int PHASE_REQUESTS = 280;
   localparam int DRAIN_LIMIT    = 10000;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  start     = 1'b0;
   logic                  busy;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data  = '0;

   text_console_char_writer_unit dut (
      .clock(clock), .reset(reset),
      .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5;
      clock = 1'b1;
      #5;
      clock = 1'b0;
   end

   // shadow of the console state
   logic [CELL_W-1:0] screen_shadow [0:CELL_COUNT-1];
   int unsigned       shadow_column = 0;
   int unsigned       shadow_row    = 0;
   logic [3:0]        shadow_background = 4'h0;
   logic [3:0]        shadow_foreground = 4'hF;

   req_type pending_requests [$];
   rsp_type awaited_responses [$];

   int mode_count [4] = '{0, 0, 0, 0};
   int scroll_count     = 0;
   int responses_seen   = 0;
   int mismatch_count   = 0;
   int burst_left       = 1;
   int gap_left         = 0;
   rsp_type oldest_response;

   initial begin
      for (int i = 0; i < CELL_COUNT; i++) begin
         screen_shadow[i] = BLANK_CELL;
      end
   end

   // one console step on the shadow state; returns the response it causes
   function automatic rsp_type step_console_shadow(req_type r);
      rsp_type resp;
      resp = '0;
      case (r.mode)
         MODE_PUT: begin
            if (r.char_code == CHAR_BACKSPACE) begin
               if (shadow_column != 0) shadow_column--;
            end else if (r.char_code == CHAR_NEWLINE) begin
               shadow_column = 0;
               shadow_row++;
            end else if (r.char_code >= CHAR_SPACE && r.char_code <= CHAR_LAST_PRINTABLE) begin
               screen_shadow[shadow_row * SCREEN_COLUMNS + shadow_column] =
                  {shadow_background, shadow_foreground, r.char_code};
               shadow_column++;
            end
            if (shadow_column >= SCREEN_COLUMNS) begin
               shadow_column = 0;
               shadow_row++;
            end
            // scroll up one row, blank the bottom row
            if (shadow_row >= SCREEN_ROWS) begin
               for (int i = 0; i < (SCREEN_ROWS - 1) * SCREEN_COLUMNS; i++) begin
                  screen_shadow[i] = screen_shadow[i + SCREEN_COLUMNS];
               end
               for (int i = (SCREEN_ROWS - 1) * SCREEN_COLUMNS; i < CELL_COUNT; i++) begin
                  screen_shadow[i] = BLANK_CELL;
               end
               shadow_row = SCREEN_ROWS - 1;
               scroll_count++;
            end
         end
         MODE_CLEAR: begin
            for (int i = 0; i < CELL_COUNT; i++) begin
               screen_shadow[i] = {r.clear_colour, CLEAR_FOREGROUND, CHAR_SPACE};
            end
            shadow_column = 0;
            shadow_row    = 0;
         end
         MODE_SET_CURSOR: begin
            shadow_column = (r.cursor_column > SCREEN_COLUMNS - 1) ?
                            SCREEN_COLUMNS - 1 : r.cursor_column;
            shadow_row    = (r.cursor_row > SCREEN_ROWS - 1) ? SCREEN_ROWS - 1 : r.cursor_row;
         end
         default: begin
            if (r.cell_index < CELL_COUNT) resp.cell_data = screen_shadow[r.cell_index];
         end
      endcase
      resp.cursor_location = LOC_W'(shadow_row * SCREEN_COLUMNS + shadow_column);
      return resp;
   endfunction

   // request driver: bursts of random length, random gaps between them
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            awaited_responses.push_back(step_console_shadow(req_data));
            mode_count[req_data.mode]++;
         end
         if (start && busy) begin
            // hold the request until it is taken
         end else if (gap_left != 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_requests.size() != 0) begin
            start    <= 1'b1;
            req_data <= pending_requests.pop_front();
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left--;
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   task automatic report_mismatch(string what, logic [15:0] want, logic [15:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t mismatch on %s: expected %h, got %h", $realtime, what, want, got);
   endtask

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         responses_seen++;
         if (awaited_responses.size() == 0) begin
            report_mismatch("unexpected response", 16'h0, rsp_data.cell_data);
         end else begin
            oldest_response = awaited_responses.pop_front();
            if (rsp_data.cursor_location !== oldest_response.cursor_location)
               report_mismatch("cursor_location", 16'(oldest_response.cursor_location),
                               16'(rsp_data.cursor_location));
            if (rsp_data.cell_data !== oldest_response.cell_data)
               report_mismatch("cell_data", oldest_response.cell_data, rsp_data.cell_data);
         end
      end
   end

   function automatic req_type make_request(logic [1:0] mode, logic [7:0] char_code,
                                            logic [3:0] clear_colour, logic [6:0] column,
                                            logic [4:0] row, logic [10:0] cell_index);
      req_type r;
      r.mode          = mode;
      r.char_code     = char_code;
      r.clear_colour  = clear_colour;
      r.cursor_column = column;
      r.cursor_row    = row;
      r.cell_index    = cell_index;
      return r;
   endfunction

   // every field random, so unused fields toggle too
   function automatic req_type random_request();
      return make_request(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                          4'($urandom_range(0, 15)), 7'($urandom_range(0, 127)),
                          5'($urandom_range(0, 31)), 11'($urandom_range(0, 2047)));
   endfunction

   function automatic int queue_reads();
      req_type r;
      int count;
      count = $urandom_range(1, 5);
      for (int k = 0; k < count; k++) begin
         r = random_request();
         r.mode = MODE_READ;
         // bias toward the bottom rows, where scrolling shows up
         if ($urandom_range(0, 1) == 0)
            r.cell_index = 11'($urandom_range(CELL_COUNT - 160, 2047));
         pending_requests.push_back(r);
      end
      return count;
   endfunction

   // a line of text: optional cursor placement, characters, then some reads
   function automatic int queue_text_line();
      req_type r;
      int count, len, pick;
      count = 0;
      pick  = $urandom_range(0, 9);
      if (pick < 8) begin
         r = random_request();
         r.mode = MODE_SET_CURSOR;
         r.cursor_column = 7'($urandom_range(0, 127));
         r.cursor_row    = 5'((pick < 6) ? $urandom_range(0, 31) : $urandom_range(23, 24));
         pending_requests.push_back(r);
         count++;
      end
      len = $urandom_range(1, 100);
      for (int k = 0; k < len; k++) begin
         r = random_request();
         r.mode = MODE_PUT;
         pick = $urandom_range(0, 99);
         if (pick < 6) r.char_code = CHAR_BACKSPACE;
         else if (pick < 12) r.char_code = CHAR_NEWLINE;
         else r.char_code = 8'($urandom_range(CHAR_SPACE, CHAR_LAST_PRINTABLE));
         pending_requests.push_back(r);
         count++;
      end
      if ($urandom_range(0, 1) == 0) begin
         r = random_request();
         r.mode = MODE_PUT;
         r.char_code = CHAR_NEWLINE;
         pending_requests.push_back(r);
         count++;
      end
      return count + queue_reads();
   endfunction

   function automatic int queue_segment();
      req_type r;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return queue_text_line();
      if (pick < 75) return queue_reads();
      r = random_request();
      if (pick < 78) r.mode = MODE_CLEAR;
      else if (r.mode == MODE_CLEAR) r.mode = MODE_PUT;
      pending_requests.push_back(r);
      return 1;
   endfunction

   // let the driver empty its queue, then wait out the outstanding responses
   task automatic wait_for_idle();
      int waited;
      do @(posedge clock); while (pending_requests.size() != 0 || start);
      waited = 0;
      while (awaited_responses.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (awaited_responses.size() != 0)
         report_mismatch("missing responses", 16'(awaited_responses.size()), 16'h0);
   endtask

   // write both colour registers back to back; valid stays up between them
   task automatic write_colours(logic [3:0] background, logic [3:0] foreground);
      csr_valid <= 1'b1;
      csr_index <= CSR_BACKGROUND;
      csr_data  <= background;
      do @(posedge clock); while (!csr_ready);
      shadow_background = background;
      csr_index <= CSR_FOREGROUND;
      csr_data  <= foreground;
      do @(posedge clock); while (!csr_ready);
      shadow_foreground = foreground;
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [3:0] background_table [6];
      logic [3:0] foreground_table [6];
      int queued;
      background_table = '{4'hF, 4'h0, 4'hF, 4'h0, 4'h5, 4'hA};
      foreground_table = '{4'hF, 4'h0, 4'h0, 4'hF, 4'hC, 4'h3};
      background_table[4] = 4'($urandom_range(0, 15));
      foreground_table[5] = 4'($urandom_range(0, 15));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed edges under the reset colours
      pending_requests.push_back(make_request(MODE_READ, 0, 0, 0, 0, 0));
      pending_requests.push_back(make_request(MODE_READ, 0, 0, 0, 0, 11'(CELL_COUNT - 1)));
      pending_requests.push_back(make_request(MODE_READ, 0, 0, 0, 0, 11'(CELL_COUNT)));
      pending_requests.push_back(make_request(MODE_READ, 0, 0, 0, 0, 11'h7FF));
      pending_requests.push_back(make_request(MODE_PUT, 8'h41, 0, 0, 0, 0));
      pending_requests.push_back(make_request(MODE_PUT, CHAR_SPACE, 0, 0, 0, 0));
      pending_requests.push_back(make_request(MODE_PUT, CHAR_LAST_PRINTABLE, 0, 0, 0, 0));
      pending_requests.push_back(make_request(MODE_READ, 0, 0, 0, 0, 0));
      pending_requests.push_back(make_request(MODE_PUT, CHAR_BACKSPACE, 0, 0, 0, 0));
      pending_requests.push_back(make_request(MODE_SET_CURSOR, 0, 0, 0, 0, 0));
      // backspace at column zero does nothing
      pending_requests.push_back(make_request(MODE_PUT, CHAR_BACKSPACE, 0, 0, 0, 0));
      // control bytes and high bytes are ignored
      pending_requests.push_back(make_request(MODE_PUT, 8'h00, 0, 0, 0, 0));
      pending_requests.push_back(make_request(MODE_PUT, 8'h1F, 0, 0, 0, 0));
      pending_requests.push_back(make_request(MODE_PUT, 8'h80, 0, 0, 0, 0));
      pending_requests.push_back(make_request(MODE_PUT, 8'hFF, 0, 0, 0, 0));
      // saturated cursor, then a character that wraps and scrolls
      pending_requests.push_back(make_request(MODE_SET_CURSOR, 0, 0, 7'h7F, 5'h1F, 0));
      pending_requests.push_back(make_request(MODE_PUT, 8'h5A, 0, 0, 0, 0));
      pending_requests.push_back(make_request(MODE_READ, 0, 0, 0, 0, 11'(CELL_COUNT - 81)));
      pending_requests.push_back(make_request(MODE_READ, 0, 0, 0, 0, 11'(CELL_COUNT - 1)));
      // newline on the last row scrolls
      pending_requests.push_back(make_request(MODE_PUT, CHAR_NEWLINE, 0, 0, 0, 0));
      pending_requests.push_back(make_request(MODE_READ, 0, 0, 0, 0, 11'(CELL_COUNT - 161)));
      pending_requests.push_back(make_request(MODE_CLEAR, 0, 4'hF, 0, 0, 0));
      pending_requests.push_back(make_request(MODE_READ, 0, 0, 0, 0, 11'd1000));
      pending_requests.push_back(make_request(MODE_CLEAR, 0, 4'h0, 0, 0, 0));
      pending_requests.push_back(make_request(MODE_READ, 0, 0, 0, 0, 0));
      wait_for_idle();

      // random phases, one colour setting each
      for (int phase = 0; phase < 6; phase++) begin
         write_colours(background_table[phase], foreground_table[phase]);
         queued = 0;
         while (queued < PHASE_REQUESTS) queued += queue_segment();
         wait_for_idle();
      end

      repeat (10) @(posedge clock);
      $display("requests: %0d put, %0d clear, %0d set cursor, %0d read; %0d scrolls",
               mode_count[MODE_PUT], mode_count[MODE_CLEAR], mode_count[MODE_SET_CURSOR],
               mode_count[MODE_READ], scroll_count);
      $display("responses checked: %0d, mismatches: %0d", responses_seen, mismatch_count);
      if (mismatch_count == 0 && awaited_responses.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // watchdog: far beyond a run where every request scrolls
   initial begin
      #200000000;
      $display("FAIL");
      $finish;
   end

endmodule

>>> sim.f
src/tccw_pkg.sv
src/tccw_ram.sv
src/text_console_char_writer_unit.sv
test/testbench.sv
